### rtl/pscp_pkg.sv
// ----------------------------------------------------------------------------
// pscp_pkg: shared types and constants for the closest-point pipeline
// Coordinate widths, region codes and the inter-stage payload types.
// ----------------------------------------------------------------------------
package pscp_pkg;

  localparam int unsigned CoordWidth = 32;
  localparam int unsigned DiffWidth  = CoordWidth + 1;
  localparam int unsigned MagWidth   = CoordWidth + 1;
  localparam int unsigned ProdWidth  = 2 * MagWidth;
  localparam int unsigned WideWidth  = ProdWidth + 1;
  localparam int unsigned FracWidth  = 32;
  localparam int unsigned DistWidth  = 63;
  localparam int unsigned InWidth    = 6 * CoordWidth;
  localparam int unsigned OutWidth   = 136;

  typedef enum logic [1:0] {
    REGION_START    = 2'd0,
    REGION_END      = 2'd1,
    REGION_INTERIOR = 2'd2
  } region_e;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [DiffWidth-1:0]  diff_t;

  // Projection terms handed to the divider.
  typedef struct packed {
    coord_t                 px;
    coord_t                 py;
    coord_t                 ax;
    coord_t                 ay;
    coord_t                 bx;
    coord_t                 by;
    diff_t                  abx;
    diff_t                  aby;
    logic [WideWidth-1:0]   dot;
    logic [WideWidth-1:0]   len;
  } proj_t;

  // Divider output: fraction plus geometry for the final stages.
  typedef struct packed {
    coord_t                 px;
    coord_t                 py;
    coord_t                 ax;
    coord_t                 ay;
    coord_t                 bx;
    coord_t                 by;
    diff_t                  abx;
    diff_t                  aby;
    logic [FracWidth-1:0]   frac;
    region_e                region;
  } frac_t;

  function automatic logic [MagWidth-1:0] mag_f(input logic signed [DiffWidth-1:0] v);
    logic signed [DiffWidth:0] e;
    e = {v[DiffWidth-1], v};
    mag_f = e[DiffWidth] ? MagWidth'(-e) : MagWidth'(e);
  endfunction

endpackage

### rtl/pscp_proj.sv
// ----------------------------------------------------------------------------
// pscp_proj: projection terms
// Three stages: differences, products, dot and squared length.
// ----------------------------------------------------------------------------
module pscp_proj import pscp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  coord_t px_i,
  input  coord_t py_i,
  input  coord_t ax_i,
  input  coord_t ay_i,
  input  coord_t bx_i,
  input  coord_t by_i,
  output logic   valid_o,
  output proj_t  proj_o
);

  typedef struct packed {
    coord_t px; coord_t py; coord_t ax; coord_t ay; coord_t bx; coord_t by;
    diff_t abx; diff_t aby; diff_t apx; diff_t apy;
  } s1_t;

  typedef struct packed {
    coord_t px; coord_t py; coord_t ax; coord_t ay; coord_t bx; coord_t by;
    diff_t abx; diff_t aby;
    logic signed [WideWidth-1:0] dx;
    logic signed [WideWidth-1:0] dy;
    logic [ProdWidth-1:0] lx;
    logic [ProdWidth-1:0] ly;
  } s2_t;

  logic [2:0] vld_q;
  s1_t        s1_d, s1_q;
  s2_t        s2_d, s2_q;
  proj_t      s3_d, s3_q;

  always_comb begin
    s1_d.px  = px_i;  s1_d.py = py_i;
    s1_d.ax  = ax_i;  s1_d.ay = ay_i;
    s1_d.bx  = bx_i;  s1_d.by = by_i;
    s1_d.abx = DiffWidth'(bx_i) - DiffWidth'(ax_i);
    s1_d.aby = DiffWidth'(by_i) - DiffWidth'(ay_i);
    s1_d.apx = DiffWidth'(px_i) - DiffWidth'(ax_i);
    s1_d.apy = DiffWidth'(py_i) - DiffWidth'(ay_i);
  end

  always_comb begin
    s2_d.px = s1_q.px; s2_d.py = s1_q.py;
    s2_d.ax = s1_q.ax; s2_d.ay = s1_q.ay;
    s2_d.bx = s1_q.bx; s2_d.by = s1_q.by;
    s2_d.abx = s1_q.abx; s2_d.aby = s1_q.aby;
    s2_d.dx = WideWidth'(s1_q.abx) * WideWidth'(s1_q.apx);
    s2_d.dy = WideWidth'(s1_q.aby) * WideWidth'(s1_q.apy);
    s2_d.lx = mag_f(s1_q.abx) * mag_f(s1_q.abx);
    s2_d.ly = mag_f(s1_q.aby) * mag_f(s1_q.aby);
  end

  always_comb begin
    s3_d.px = s2_q.px; s3_d.py = s2_q.py;
    s3_d.ax = s2_q.ax; s3_d.ay = s2_q.ay;
    s3_d.bx = s2_q.bx; s3_d.by = s2_q.by;
    s3_d.abx = s2_q.abx; s3_d.aby = s2_q.aby;
    s3_d.dot = s2_q.dx + s2_q.dy;
    s3_d.len = WideWidth'(s2_q.lx) + WideWidth'(s2_q.ly);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
    end
  end

  assign valid_o = vld_q[2];
  assign proj_o  = s3_q;

  // squared length never negative
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !s3_q.len[WideWidth-1])
    else $error("negative squared length");

endmodule

### rtl/pscp_div.sv
// ----------------------------------------------------------------------------
// pscp_div: pipelined fraction divider
// Region decision, then one restoring quotient bit per stage.
// ----------------------------------------------------------------------------
module pscp_div import pscp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  proj_t proj_i,
  output logic  valid_o,
  output frac_t frac_o
);

  localparam int unsigned RemWidth = WideWidth + 1;

  frac_t                 meta_q [FracWidth+1];
  logic [RemWidth-1:0]   rem_q  [FracWidth+1];
  logic [WideWidth-1:0]  den_q  [FracWidth+1];
  logic [FracWidth:0]    vld_q;

  frac_t   meta0_d;
  logic    nonpos;

  always_comb begin
    nonpos = proj_i.dot[WideWidth-1] || (proj_i.dot == '0);
    meta0_d.px = proj_i.px; meta0_d.py = proj_i.py;
    meta0_d.ax = proj_i.ax; meta0_d.ay = proj_i.ay;
    meta0_d.bx = proj_i.bx; meta0_d.by = proj_i.by;
    meta0_d.abx = proj_i.abx; meta0_d.aby = proj_i.aby;
    meta0_d.frac = '0;
    if (proj_i.len == '0 || nonpos) begin
      meta0_d.region = REGION_START;
    end else if (proj_i.dot >= proj_i.len) begin
      meta0_d.region = REGION_END;
    end else begin
      meta0_d.region = REGION_INTERIOR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[FracWidth-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      meta_q[0] <= meta0_d;
      rem_q[0]  <= RemWidth'(proj_i.dot);
      den_q[0]  <= proj_i.len;
    end
  end

  for (genvar g = 0; g < FracWidth; g++) begin : g_bit
    logic [RemWidth-1:0] sh;
    logic                ge;
    frac_t               m_d;
    always_comb begin
      sh  = {rem_q[g][RemWidth-2:0], 1'b0};
      ge  = sh >= RemWidth'(den_q[g]);
      m_d = meta_q[g];
      m_d.frac = {meta_q[g].frac[FracWidth-2:0], ge};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        meta_q[g+1] <= m_d;
        rem_q[g+1]  <= ge ? sh - RemWidth'(den_q[g]) : sh;
        den_q[g+1]  <= den_q[g];
      end
    end
  end

  assign valid_o = vld_q[FracWidth];
  assign frac_o  = meta_q[FracWidth];

  // remainder stays below divisor for interior items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && frac_o.region == REGION_INTERIOR
      |-> rem_q[FracWidth] < RemWidth'(den_q[FracWidth]))
    else $error("divider remainder out of range");

endmodule

### rtl/pscp_dist.sv
// ----------------------------------------------------------------------------
// pscp_dist: closest point and squared distance
// Scale, select point, square deltas, sum and saturate.
// ----------------------------------------------------------------------------
module pscp_dist import pscp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  frac_t                 frac_i,
  output logic                  valid_o,
  output coord_t                cx_o,
  output coord_t                cy_o,
  output logic [DistWidth-1:0]  dist_o,
  output region_e               region_o,
  output logic                  sat_o
);

  localparam int unsigned SWidth = DiffWidth + FracWidth + 1;

  typedef struct packed {
    coord_t px; coord_t py; coord_t ax; coord_t ay; coord_t bx; coord_t by;
    logic signed [SWidth-1:0] sx;
    logic signed [SWidth-1:0] sy;
    region_e region;
  } m1_t;

  typedef struct packed {
    coord_t cx; coord_t cy;
    logic [MagWidth-1:0] mx; logic [MagWidth-1:0] my;
    region_e region;
  } m2_t;

  typedef struct packed {
    coord_t cx; coord_t cy;
    logic [ProdWidth-1:0] qx; logic [ProdWidth-1:0] qy;
    region_e region;
  } m3_t;

  logic [3:0] vld_q;
  m1_t m1_d, m1_q;
  m2_t m2_d, m2_q;
  m3_t m3_d, m3_q;
  coord_t cx_q, cy_q;
  logic [DistWidth-1:0] dist_q;
  region_e region_q;
  logic sat_q;

  always_comb begin
    m1_d.px = frac_i.px; m1_d.py = frac_i.py;
    m1_d.ax = frac_i.ax; m1_d.ay = frac_i.ay;
    m1_d.bx = frac_i.bx; m1_d.by = frac_i.by;
    m1_d.region = frac_i.region;
    // signed times unsigned fraction; arithmetic shift later floors
    m1_d.sx = SWidth'(frac_i.abx) * $signed({1'b0, frac_i.frac});
    m1_d.sy = SWidth'(frac_i.aby) * $signed({1'b0, frac_i.frac});
  end

  always_comb begin
    logic signed [DiffWidth-1:0] ox, oy, cxw, cyw;
    logic signed [SWidth-1:0]    shx, shy;
    shx = m1_q.sx >>> FracWidth;
    shy = m1_q.sy >>> FracWidth;
    unique case (m1_q.region)
      REGION_END: begin
        cxw = DiffWidth'(m1_q.bx); cyw = DiffWidth'(m1_q.by);
      end
      REGION_INTERIOR: begin
        cxw = DiffWidth'(m1_q.ax) + DiffWidth'(shx);
        cyw = DiffWidth'(m1_q.ay) + DiffWidth'(shy);
      end
      default: begin
        cxw = DiffWidth'(m1_q.ax); cyw = DiffWidth'(m1_q.ay);
      end
    endcase
    ox = DiffWidth'(m1_q.px) - cxw;
    oy = DiffWidth'(m1_q.py) - cyw;
    m2_d.cx = CoordWidth'(cxw);
    m2_d.cy = CoordWidth'(cyw);
    m2_d.mx = mag_f(ox);
    m2_d.my = mag_f(oy);
    m2_d.region = m1_q.region;
  end

  always_comb begin
    m3_d.cx = m2_q.cx; m3_d.cy = m2_q.cy; m3_d.region = m2_q.region;
    m3_d.qx = m2_q.mx * m2_q.mx;
    m3_d.qy = m2_q.my * m2_q.my;
  end

  logic [ProdWidth:0] sum;
  logic               over;
  assign sum  = {1'b0, m3_q.qx} + {1'b0, m3_q.qy};
  assign over = |sum[ProdWidth:DistWidth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q     <= m1_d;
      m2_q     <= m2_d;
      m3_q     <= m3_d;
      cx_q     <= m3_q.cx;
      cy_q     <= m3_q.cy;
      region_q <= m3_q.region;
      sat_q    <= over;
      dist_q   <= over ? {DistWidth{1'b1}} : sum[DistWidth-1:0];
    end
  end

  assign valid_o  = vld_q[3];
  assign cx_o     = cx_q;
  assign cy_o     = cy_q;
  assign dist_o   = dist_q;
  assign region_o = region_q;
  assign sat_o    = sat_q;

  // saturation flag and saturated value agree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && sat_o |-> dist_o == {DistWidth{1'b1}})
    else $error("saturation flag without saturated distance");

endmodule

### rtl/point_segment_closest_point.sv
// ----------------------------------------------------------------------------
// point_segment_closest_point: closest point on a 2-D segment
// Projects a point onto a segment, clamps, returns point, region, distance.
// ----------------------------------------------------------------------------
// channel   dir  payload
// s_axis    in   tdata 192b: px, py, ax, ay, bx, by
// m_axis    out  tdata 136b: cx, cy, dist_sq, region, dist_saturated
//
// One beat per cycle while the output is empty or taken; the pipeline depth
// is set by the 32-stage restoring divider for the projection fraction.
// Asynchronous active-low reset clears all valid bits.
// The whole pipeline advances when the output register is empty or taken;
// a stall freezes every stage, nothing dropped or repeated.
// ----------------------------------------------------------------------------
module point_segment_closest_point import pscp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InWidth-1:0]  s_axis_tdata,  // point_x, point_y, seg_start_x,
                                              // seg_start_y, seg_end_x, seg_end_y
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutWidth-1:0] m_axis_tdata   // closest_x, closest_y, dist_sq,
                                              // region, dist_saturated, zero pad
);

  logic    en;
  logic    pv, dv;
  proj_t   proj;
  frac_t   frac;
  coord_t  cx, cy;
  logic [DistWidth-1:0] dist_sq;
  region_e region;
  logic    sat;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  pscp_proj u_proj (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(s_axis_tvalid),
    .px_i(s_axis_tdata[31:0]),    .py_i(s_axis_tdata[63:32]),
    .ax_i(s_axis_tdata[95:64]),   .ay_i(s_axis_tdata[127:96]),
    .bx_i(s_axis_tdata[159:128]), .by_i(s_axis_tdata[191:160]),
    .valid_o(pv), .proj_o(proj)
  );

  pscp_div u_div (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(pv), .proj_i(proj),
    .valid_o(dv), .frac_o(frac)
  );

  pscp_dist u_dist (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(dv), .frac_i(frac),
    .valid_o(m_axis_tvalid),
    .cx_o(cx), .cy_o(cy), .dist_o(dist_sq), .region_o(region), .sat_o(sat)
  );

  assign m_axis_tdata = {6'b0, sat, region, dist_sq, cy, cx};

  // held output beat stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed under stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[128:127] != 2'd3)
    else $error("bad region code");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready not tied to pipeline advance");

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb: closest point on a segment, self-checking bench
// Drives random and corner point/segment queries with random gaps, predicts
// closest point, region and squared distance, checks every output beat.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pscp_pkg::*;

  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [62:0] dist_sq;
    region_e     region;
    logic        sat;
  } closest_t;

  class closest_board;
    closest_t pending[$];
    int       n_bad;

    function automatic closest_t project(logic [191:0] q);
      logic signed [63:0]  px, py, ax, ay, bx, by, abx, aby, apx, apy, cx, cy;
      logic signed [127:0] dot, len, tq, qx, qy;
      logic [63:0]         mx, my;
      logic [127:0]        sum;
      closest_t            r;
      px = 64'(signed'(q[31:0]));    py = 64'(signed'(q[63:32]));
      ax = 64'(signed'(q[95:64]));   ay = 64'(signed'(q[127:96]));
      bx = 64'(signed'(q[159:128])); by = 64'(signed'(q[191:160]));
      abx = bx - ax; aby = by - ay; apx = px - ax; apy = py - ay;
      dot = 128'(abx) * 128'(apx) + 128'(aby) * 128'(apy);
      len = 128'(abx) * 128'(abx) + 128'(aby) * 128'(aby);
      if (len == 0 || dot <= 0) begin
        cx = ax; cy = ay; r.region = REGION_START;
      end else if (dot >= len) begin
        cx = bx; cy = by; r.region = REGION_END;
      end else begin
        tq = (dot <<< 32) / len;
        // arithmetic shift gives floor toward minus infinity
        qx = (128'(abx) * tq) >>> 32;
        qy = (128'(aby) * tq) >>> 32;
        cx = ax + 64'(qx); cy = ay + 64'(qy);
        r.region = REGION_INTERIOR;
      end
      mx = px - cx; my = py - cy;
      sum = 128'(signed'(mx)) * 128'(signed'(mx)) + 128'(signed'(my)) * 128'(signed'(my));
      r.cx = cx[31:0]; r.cy = cy[31:0];
      r.sat = sum > 128'h7FFF_FFFF_FFFF_FFFF;
      r.dist_sq = r.sat ? '1 : sum[62:0];
      return r;
    endfunction

    function void note_query(logic [191:0] q);
      pending.push_back(project(q));
    endfunction

    function void check_result(logic [135:0] d);
      closest_t e, a;
      a.cx = d[31:0]; a.cy = d[63:32]; a.dist_sq = d[126:64];
      a.region = region_e'(d[128:127]); a.sat = d[129];
      if (pending.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected beat %h", d);
        return;
      end
      e = pending.pop_front();
      if (e !== a) begin
        n_bad++;
        if (n_bad <= 10)
          $display("mismatch exp cx=%h cy=%h d=%h rg=%0d s=%b got cx=%h cy=%h d=%h rg=%0d s=%b",
                   e.cx, e.cy, e.dist_sq, e.region, e.sat,
                   a.cx, a.cy, a.dist_sq, a.region, a.sat);
      end
    endfunction
  endclass

  logic         clk_i, rst_ni;
  logic         s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [191:0] s_axis_tdata;
  logic [135:0] m_axis_tdata;
  closest_board board;
  logic         hold_off;
  int           idle_cycles;

  point_segment_closest_point uut (.*);

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'(signed'($urandom_range(0, 2000)) - 1000) <<< 16;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'(signed'($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  // valid drops only when a gap follows, so back-to-back beats keep it high
  task automatic send_query(logic [191:0] q);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= q;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_query(q);
  endtask

  // receiver: random stalls, one long hold-off while the sender keeps offering
  initial begin
    int w;
    m_axis_tready = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        m_axis_tready <= 0;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
      w = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 19);
      if (w != 0) begin
        m_axis_tready <= 0;
        repeat (w) @(posedge clk_i);
      end
      m_axis_tready <= 1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    logic [31:0] v[6];
    logic [191:0] q;
    int m, waited;
    board = new;
    hold_off = 0;
    idle_cycles = 0;
    rst_ni = 0; s_axis_tvalid = 0; s_axis_tdata = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // corners: degenerate, before start, interior, extremes
    send_query({32'd0, 32'd0, 32'd0, 32'd0, 32'd5, 32'd7});
    send_query({32'd0, 32'h10000, 32'd0, 32'd0, 32'h10000, 32'hFFFF0000});
    send_query({32'd0, 32'h30000, 32'd0, 32'd0, 32'h50000, 32'd0});
    send_query({32'd0, 32'h40000, 32'd0, 32'd0, 32'h18000, 32'h30000});
    send_query({32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                32'h7FFFFFFF, 32'h80000000});
    send_query({32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                32'h80000000, 32'h7FFFFFFF});
    send_query({32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                32'h80000000, 32'h80000000});
    send_query({32'hFFFFFFFF, 32'h00000001, 32'h00000001, 32'hFFFFFFFF,
                32'h00000003, 32'hFFFFFFFD});
    send_query({32'h80000000, 32'h0, 32'h7FFFFFFF, 32'h0, 32'h0, 32'h7FFFFFFF});
    send_query({32'hFFFF, 32'hFFFF, 32'h0, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF});
    send_query({32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
    for (int i = 0; i < 1040; i++) begin
      if (i == 300) hold_off = 1;
      m = $urandom_range(0, 3);
      foreach (v[k]) v[k] = $urandom_range(0, 7) == 0 ? rand_coord($urandom_range(0, 3))
                                                     : rand_coord(m);
      if ($urandom_range(0, 19) == 0) begin
        v[4] = v[2]; v[5] = v[3];
      end
      q = {v[5], v[4], v[3], v[2], v[1], v[0]};
      send_query(q);
    end
    s_axis_tvalid <= 0;
    waited = 0;
    while (board.pending.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (60) @(posedge clk_i);
    if (board.n_bad == 0 && board.pending.size() == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule
